>>> rtl/tatm_pkg.sv
// ----------------------------------------------------------------------------
// tatm_pkg
// Shared types and constants of the two-axis move-time estimator.
// ----------------------------------------------------------------------------
package tatm_pkg;

   localparam int FIELD_W   = 16;
   localparam int TIME_W    = 32;
   localparam int DEN_W     = 32;
   localparam int DIV_W     = 58;
   localparam int ROOT_W    = DIV_W / 2;
   localparam int SQ_REM_W  = 32;

   localparam logic [19:0] US_PER_S  = 20'd1000000;
   // 4e12 = 976562500 * 2^12
   localparam logic [29:0] TRI_SCALE = 30'd976562500;
   localparam int          TRI_SHIFT = 12;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_VERT_SPEED  = 3'd0;
   localparam logic [2:0] REG_VERT_ACCEL  = 3'd1;
   localparam logic [2:0] REG_HORIZ_SPEED = 3'd2;
   localparam logic [2:0] REG_HORIZ_ACCEL = 3'd3;
   localparam logic [2:0] REG_ROBOT_Y     = 3'd4;
   localparam logic [2:0] REG_ROBOT_Z     = 3'd5;

   typedef struct packed {
      logic [FIELD_W-1:0] target_y;
      logic [FIELD_W-1:0] target_z;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] move_time_us;
      logic              limiting_axis;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             trap;
      logic [DEN_W-1:0] rem;
      logic [DIV_W-1:0] nq;
      logic [DEN_W-1:0] den;
   } div_beat_type;

   typedef struct packed {
      logic                valid;
      logic                trap;
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
      logic [DIV_W-1:0]    rad;
   } sqrt_beat_type;

endpackage

>>> rtl/two_axis_trapezoid_move_time.sv
// ----------------------------------------------------------------------------
// two_axis_trapezoid_move_time
// Trapezoidal or triangular move time of a two-axis target, larger axis wins.
// ----------------------------------------------------------------------------
// Usage: a target (target_y, target_z) arrives as one beat on req_*; one beat
// per target leaves on rsp_* carrying the larger axis time in microseconds
// (saturated) and the axis that sets it, 1 on a tie.
// Speed, acceleration and robot position sit in six 16-bit registers on the
// csr_* port at byte addresses 0,4,..,20; write them only while idle.
// From request beat to response valid a beat passes two registers of distance
// and products, 58 divider cells (one quotient bit each), 29 square-root
// cells (one root bit each) and the output register.
// Throughput is one target per cycle while req_ready is high; every cell
// hands its beat on to the next each cycle that req_ready is high.
// When the receiver stalls, the response register holds its beat and the
// cell rows keep moving until a valid beat reaches the last cell; only then
// does req_ready drop.
// Reset empties the pipeline and loads speeds and accelerations with 1000
// and robot positions with 0.
// ----------------------------------------------------------------------------
module two_axis_trapezoid_move_time #(
   parameter int POS_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tatm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tatm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tatm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [tatm_pkg::FIELD_W-1:0] vert_speed_ff;
   logic [tatm_pkg::FIELD_W-1:0] vert_accel_ff;
   logic [tatm_pkg::FIELD_W-1:0] horiz_speed_ff;
   logic [tatm_pkg::FIELD_W-1:0] horiz_accel_ff;
   logic [tatm_pkg::FIELD_W-1:0] robot_y_ff;
   logic [tatm_pkg::FIELD_W-1:0] robot_z_ff;
   logic [2:0]                   reg_index;
   logic                         csr_write;
   logic [tatm_pkg::FIELD_W-1:0] wr_value;

   logic                         en;
   logic                         v_valid;
   logic                         h_valid;
   logic                         last_valid;
   logic [tatm_pkg::TIME_W-1:0]  v_time;
   logic [tatm_pkg::TIME_W-1:0]  h_time;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   tatm_pkg::rsp_type            rsp_data_ff;
   tatm_pkg::rsp_type            rsp_data_in;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_value   = csr_pwdata[tatm_pkg::FIELD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_speed_ff  <= 16'd1000;
         vert_accel_ff  <= 16'd1000;
         horiz_speed_ff <= 16'd1000;
         horiz_accel_ff <= 16'd1000;
         robot_y_ff     <= 16'd0;
         robot_z_ff     <= 16'd0;
      end else if (csr_write) begin
         unique case (reg_index)
            tatm_pkg::REG_VERT_SPEED:  vert_speed_ff  <= wr_value;
            tatm_pkg::REG_VERT_ACCEL:  vert_accel_ff  <= wr_value;
            tatm_pkg::REG_HORIZ_SPEED: horiz_speed_ff <= wr_value;
            tatm_pkg::REG_HORIZ_ACCEL: horiz_accel_ff <= wr_value;
            tatm_pkg::REG_ROBOT_Y:     robot_y_ff     <= wr_value;
            tatm_pkg::REG_ROBOT_Z:     robot_z_ff     <= wr_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         tatm_pkg::REG_VERT_SPEED:  csr_prdata = 32'(vert_speed_ff);
         tatm_pkg::REG_VERT_ACCEL:  csr_prdata = 32'(vert_accel_ff);
         tatm_pkg::REG_HORIZ_SPEED: csr_prdata = 32'(horiz_speed_ff);
         tatm_pkg::REG_HORIZ_ACCEL: csr_prdata = 32'(horiz_accel_ff);
         tatm_pkg::REG_ROBOT_Y:     csr_prdata = 32'(robot_y_ff);
         tatm_pkg::REG_ROBOT_Z:     csr_prdata = 32'(robot_z_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // rows only stop when a finished beat would collide with a held response
   assign en        = !(rsp_valid_ff && !rsp_ready && last_valid);
   assign req_ready = en;

   tatm_axis #(.POS_BITS(POS_BITS)) u_vert (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos       (robot_y_ff),
      .tgt       (req_data.target_y),
      .speed     (vert_speed_ff),
      .accel     (vert_accel_ff),
      .out_valid (v_valid),
      .time_us   (v_time)
   );

   tatm_axis #(.POS_BITS(POS_BITS)) u_horiz (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos       (robot_z_ff),
      .tgt       (req_data.target_z),
      .speed     (horiz_speed_ff),
      .accel     (horiz_accel_ff),
      .out_valid (h_valid),
      .time_us   (h_time)
   );

   assign last_valid = v_valid && h_valid;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (en && last_valid) begin
         rsp_valid_in = 1'b1;
         if (v_time > h_time) begin
            rsp_data_in.move_time_us  = v_time;
            rsp_data_in.limiting_axis = 1'b0;
         end else begin
            rsp_data_in.move_time_us  = h_time;
            rsp_data_in.limiting_axis = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // both axis rows move in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      v_valid == h_valid)
      else $error("axis rows out of step");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && last_valid))
      else $error("input stalled without a blocked response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && last_valid) |=> rsp_valid && last_valid)
      else $error("finished beat lost while response held");

endmodule

>>> rtl/tatm_div_cell.sv
// ----------------------------------------------------------------------------
// tatm_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module tatm_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  tatm_pkg::div_beat_type beat_in,
   output tatm_pkg::div_beat_type beat_out
);

   tatm_pkg::div_beat_type beat_ff;
   tatm_pkg::div_beat_type step_in;
   logic [tatm_pkg::DEN_W:0] trial;
   logic [tatm_pkg::DEN_W:0] diff;
   logic                     ge;

   always_comb begin
      trial   = {beat_in.rem, beat_in.nq[tatm_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, beat_in.den};
      diff    = trial - {1'b0, beat_in.den};
      step_in = beat_in;
      step_in.rem = ge ? diff[tatm_pkg::DEN_W-1:0] : trial[tatm_pkg::DEN_W-1:0];
      step_in.nq  = {beat_in.nq[tatm_pkg::DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (en) begin
         beat_ff.valid <= step_in.valid;
      end
      if (en) begin
         beat_ff.trap <= step_in.trap;
         beat_ff.rem  <= step_in.rem;
         beat_ff.nq   <= step_in.nq;
         beat_ff.den  <= step_in.den;
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> rtl/tatm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tatm_sqrt_cell
// One restoring square-root step: one root bit per cell.
// ----------------------------------------------------------------------------
module tatm_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  tatm_pkg::sqrt_beat_type beat_in,
   output tatm_pkg::sqrt_beat_type beat_out
);

   tatm_pkg::sqrt_beat_type beat_ff;
   tatm_pkg::sqrt_beat_type step_in;
   logic [tatm_pkg::SQ_REM_W-1:0] part;
   logic [tatm_pkg::SQ_REM_W-1:0] trial;
   logic                          ge;

   always_comb begin
      part  = {beat_in.rem[tatm_pkg::SQ_REM_W-3:0], beat_in.rad[tatm_pkg::DIV_W-1 -: 2]};
      trial = {1'b0, beat_in.root, 2'b01};
      ge    = part >= trial;
      step_in = beat_in;
      // trapezoid beats carry their quotient through untouched
      if (!beat_in.trap) begin
         step_in.rem  = ge ? (part - trial) : part;
         step_in.root = {beat_in.root[tatm_pkg::ROOT_W-2:0], ge};
         step_in.rad  = {beat_in.rad[tatm_pkg::DIV_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (en) begin
         beat_ff.valid <= step_in.valid;
      end
      if (en) begin
         beat_ff.trap <= step_in.trap;
         beat_ff.rem  <= step_in.rem;
         beat_ff.root <= step_in.root;
         beat_ff.rad  <= step_in.rad;
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> rtl/tatm_axis.sv
// ----------------------------------------------------------------------------
// tatm_axis
// Move time of one axis: distance and products, then a row of divider
// cells and a row of square-root cells.
// ----------------------------------------------------------------------------
module tatm_axis #(
   parameter int POS_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [tatm_pkg::FIELD_W-1:0] pos,
   input  logic [tatm_pkg::FIELD_W-1:0] tgt,
   input  logic [tatm_pkg::FIELD_W-1:0] speed,
   input  logic [tatm_pkg::FIELD_W-1:0] accel,
   output logic                         out_valid,
   output logic [tatm_pkg::TIME_W-1:0]  time_us
);

   localparam int PW = (POS_BITS < tatm_pkg::FIELD_W) ? POS_BITS : tatm_pkg::FIELD_W;

   logic [PW-1:0]                p_pos;
   logic [PW-1:0]                p_tgt;
   logic [PW-1:0]                gap;
   logic [tatm_pkg::FIELD_W-1:0] d_in;
   logic [tatm_pkg::FIELD_W-1:0] v_in;
   logic [tatm_pkg::FIELD_W-1:0] a_in;

   logic                         s1_valid_ff;
   logic [31:0]                  da_ff;
   logic [31:0]                  vv_ff;
   logic [31:0]                  va_ff;
   logic [tatm_pkg::FIELD_W-1:0] d_ff;
   logic [tatm_pkg::FIELD_W-1:0] a_ff;

   logic                         trap_in;
   logic [32:0]                  num;
   logic [tatm_pkg::DIV_W-1:0]   n_trap;
   logic [tatm_pkg::DIV_W-1:0]   n_tri;
   tatm_pkg::div_beat_type       head_in;
   tatm_pkg::div_beat_type       head_ff;

   tatm_pkg::div_beat_type       div_link  [0:tatm_pkg::DIV_W];
   tatm_pkg::sqrt_beat_type      sqrt_link [0:tatm_pkg::ROOT_W];
   tatm_pkg::sqrt_beat_type      tail;

   always_comb begin
      p_pos = pos[PW-1:0];
      p_tgt = tgt[PW-1:0];
      gap   = (p_pos > p_tgt) ? (p_pos - p_tgt) : (p_tgt - p_pos);
      d_in  = tatm_pkg::FIELD_W'(gap);
      v_in  = (speed == '0) ? tatm_pkg::FIELD_W'(1) : speed;
      a_in  = (accel == '0) ? tatm_pkg::FIELD_W'(1) : accel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff <= 32'(d_in) * 32'(a_in);
         vv_ff <= 32'(v_in) * 32'(v_in);
         va_ff <= 32'(v_in) * 32'(a_in);
         d_ff  <= d_in;
         a_ff  <= a_in;
      end
   end

   // equal products count as a triangle
   always_comb begin
      trap_in = da_ff > vv_ff;
      num     = 33'(da_ff) + 33'(vv_ff);
      n_trap  = tatm_pkg::DIV_W'(num) * tatm_pkg::DIV_W'(tatm_pkg::US_PER_S);
      n_tri   = (tatm_pkg::DIV_W'(d_ff) * tatm_pkg::DIV_W'(tatm_pkg::TRI_SCALE))
                << tatm_pkg::TRI_SHIFT;
      head_in.valid = s1_valid_ff;
      head_in.trap  = trap_in;
      head_in.rem   = '0;
      head_in.nq    = trap_in ? n_trap : n_tri;
      head_in.den   = trap_in ? va_ff : tatm_pkg::DEN_W'(a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (en) begin
         head_ff.valid <= head_in.valid;
      end
      if (en) begin
         head_ff.trap <= head_in.trap;
         head_ff.rem  <= head_in.rem;
         head_ff.nq   <= head_in.nq;
         head_ff.den  <= head_in.den;
      end
   end

   assign div_link[0] = head_ff;

   for (genvar i = 0; i < tatm_pkg::DIV_W; i++) begin : g_div
      tatm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .beat_in  (div_link[i]),
         .beat_out (div_link[i+1])
      );
   end

   always_comb begin
      sqrt_link[0].valid = div_link[tatm_pkg::DIV_W].valid;
      sqrt_link[0].trap  = div_link[tatm_pkg::DIV_W].trap;
      sqrt_link[0].rem   = '0;
      sqrt_link[0].root  = '0;
      sqrt_link[0].rad   = div_link[tatm_pkg::DIV_W].nq;
   end

   for (genvar j = 0; j < tatm_pkg::ROOT_W; j++) begin : g_sqrt
      tatm_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .beat_in  (sqrt_link[j]),
         .beat_out (sqrt_link[j+1])
      );
   end

   assign tail = sqrt_link[tatm_pkg::ROOT_W];

   always_comb begin
      out_valid = tail.valid;
      if (tail.trap) begin
         time_us = (tail.rad[tatm_pkg::DIV_W-1:tatm_pkg::TIME_W] != '0) ? '1
                 : tail.rad[tatm_pkg::TIME_W-1:0];
      end else begin
         time_us = tatm_pkg::TIME_W'(tail.root);
      end
   end

endmodule

>>> tb/tb_two_axis_trapezoid_move_time.sv
// ----------------------------------------------------------------------------
// tb_two_axis_trapezoid_move_time
// Self-checking bench: random and directed targets under several register
// settings, results compared in order against an exact integer predictor.
// ----------------------------------------------------------------------------
class move_time_board;
   tatm_pkg::rsp_type pending[$];
   int mismatches;
   int checked;
   logic [15:0] vs, va, hs, ha, ry, rz;

   function new();
      mismatches = 0;
      checked = 0;
      vs = 1000; va = 1000; hs = 1000; ha = 1000; ry = 0; rz = 0;
   endfunction

   function logic [63:0] root64(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function logic [31:0] axis_us(logic [15:0] pos, logic [15:0] tgt,
                                 logic [15:0] sp, logic [15:0] ac);
      logic [63:0] d, v, a, num, den, q, r, us, qd, rd, hi, lo, sq;
      d = (pos > tgt) ? 64'(pos - tgt) : 64'(tgt - pos);
      v = (sp == 0) ? 64'd1 : 64'(sp);
      a = (ac == 0) ? 64'd1 : 64'(ac);
      if (d * a > v * v) begin
         num = d * a + v * v;
         den = v * a;
         q = num / den;
         r = num % den;
         us = q * 64'd1000000 + (r * 64'd1000000) / den;
      end else begin
         qd = d / a;
         rd = d % a;
         // qd < 65536 so no overflow of qd*4e12
         hi = qd * 64'd4000000000000;
         lo = (rd * 64'd4000000000000) / a;
         sq = (hi > ~64'd0 - lo) ? ~64'd0 : hi + lo;
         us = root64(sq);
      end
      return (us > 64'hFFFFFFFF) ? 32'hFFFFFFFF : us[31:0];
   endfunction

   function void note_target(tatm_pkg::req_type t);
      tatm_pkg::rsp_type e;
      logic [31:0] tv, th;
      tv = axis_us(ry, t.target_y, vs, va);
      th = axis_us(rz, t.target_z, hs, ha);
      if (tv > th) begin
         e.move_time_us = tv; e.limiting_axis = 1'b0;
      end else begin
         e.move_time_us = th; e.limiting_axis = 1'b1;
      end
      pending.push_back(e);
   endfunction

   function void check_time(tatm_pkg::rsp_type got);
      tatm_pkg::rsp_type e;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h", got);
         return;
      end
      e = pending.pop_front();
      if (got.move_time_us !== e.move_time_us || got.limiting_axis !== e.limiting_axis) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected time %0d axis %0d, got time %0d axis %0d",
                     e.move_time_us, e.limiting_axis, got.move_time_us, got.limiting_axis);
      end
   endfunction
endclass

module tb_two_axis_trapezoid_move_time;

   localparam int LATENCY = 90;
   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   tatm_pkg::req_type req_data;
   logic rsp_valid, rsp_ready;
   tatm_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [tatm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   move_time_board board;
   int send_idle, recv_idle;
   int idle_cycles;
   int sent;
   int settings_run;

   two_axis_trapezoid_move_time uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1; req_valid = 0; req_data = '0; rsp_ready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle = 0; recv_idle = 0; idle_cycles = 0;
   end

   // receiver and result checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_time(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("** two_axis_trapezoid_move_time: FAILED **");
         $finish;
      end
   end

   task automatic reg_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= tatm_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= {16'($urandom_range(65535)), val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         tatm_pkg::REG_VERT_SPEED:  board.vs = val;
         tatm_pkg::REG_VERT_ACCEL:  board.va = val;
         tatm_pkg::REG_HORIZ_SPEED: board.hs = val;
         tatm_pkg::REG_HORIZ_ACCEL: board.ha = val;
         tatm_pkg::REG_ROBOT_Y:     board.ry = val;
         tatm_pkg::REG_ROBOT_Z:     board.rz = val;
         default: ;
      endcase
   endtask

   task automatic send_target(logic [15:0] ty, logic [15:0] tz);
      tatm_pkg::req_type t;
      t.target_y = ty;
      t.target_z = tz;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_target(t);
      sent++;
      // valid stays high; next send either lowers it or drives a new beat
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic apply_setting(logic [15:0] vs, logic [15:0] va, logic [15:0] hs,
                                logic [15:0] ha, logic [15:0] ry, logic [15:0] rz);
      drain();
      reg_write(tatm_pkg::REG_VERT_SPEED, vs);
      reg_write(tatm_pkg::REG_VERT_ACCEL, va);
      reg_write(tatm_pkg::REG_HORIZ_SPEED, hs);
      reg_write(tatm_pkg::REG_HORIZ_ACCEL, ha);
      reg_write(tatm_pkg::REG_ROBOT_Y, ry);
      reg_write(tatm_pkg::REG_ROBOT_Z, rz);
      settings_run++;
   endtask

   function automatic logic [15:0] rnd_rate();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(1, 50));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] rnd_pos();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      int phase, k;
      sent = 0; settings_run = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset values, distance extremes, shape boundary
      send_target(0, 0);
      send_target(16'hFFFF, 16'hFFFF);
      send_target(1000, 999);
      send_target(1001, 1000);
      send_target(1, 0);
      send_target(500, 500);
      apply_setting(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_target(0, 16'hFFFF);
      send_target(16'hFFFF, 0);
      send_target(16'h8000, 16'h8000);
      apply_setting(16'hFFFF, 1, 1, 16'hFFFF, 100, 100);
      send_target(16'hFFFF, 16'hFFFF);
      send_target(0, 0);
      send_target(100, 100);
      // boundary d*a == v*v: v=10, a=10, d=10
      apply_setting(10, 10, 10, 10, 0, 0);
      send_target(10, 10);
      send_target(11, 9);
      send_target(9, 11);
      send_target(16'hFFFF, 1);

      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
         recv_idle = (phase == 0) ? 48 : (phase == 1) ? 18 : 0;
         for (k = 0; k < 4; k++) begin
            apply_setting(rnd_rate(), rnd_rate(), rnd_rate(), rnd_rate(), rnd_pos(), rnd_pos());
            repeat (170) send_target(rnd_pos(), rnd_pos());
         end
      end

      drain();
      $display("%0d targets sent under %0d register settings, %0d results checked",
               sent, settings_run + 1, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("** two_axis_trapezoid_move_time: PASSED **");
      else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("** two_axis_trapezoid_move_time: FAILED **");
      end
      $finish;
   end
endmodule

>>> two_axis_trapezoid_move_time.f
rtl/tatm_pkg.sv
rtl/tatm_div_cell.sv
rtl/tatm_sqrt_cell.sv
rtl/tatm_axis.sv
rtl/two_axis_trapezoid_move_time.sv
tb/tb_two_axis_trapezoid_move_time.sv
